FILE: hw/rtl/hpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine proximity check package
// Shared widths, fixed-point constants, register indexes, datapath structs and
// the CORDIC arctangent step function.
// ----------------------------------------------------------------------------
package hpc_pkg;

  // Field widths of the channels and the configuration port.
  localparam int LAT_W  = 25;
  localparam int LON_W  = 26;
  localparam int KIND_W = 8;
  localparam int DIST_W = 25;
  localparam int CFG_W  = 25;
  localparam int CFG_IW = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IW-1:0] REG_RADIUS     = 1'd0;
  localparam logic [CFG_IW-1:0] REG_TYPE_CHECK = 1'd1;
  localparam logic [CFG_W-1:0]  RADIUS_RST     = 25'd100;

  // Datapath geometry.
  localparam int CORDIC_STAGES = 24;
  localparam int SHW        = 5;                    // CORDIC shift index
  localparam int XW         = 44;                   // CORDIC x/y, Q40
  localparam int ZW         = 34;                   // CORDIC angle, Q30
  localparam int ZRW        = 35 - CORDIC_STAGES;   // residual angle after the last step
  localparam int TW         = 32;                   // sine and cosine, Q30
  localparam int RTW        = 62;                   // square root datapath
  localparam int RKW        = 5;
  localparam int ROOT_STEPS = 31;
  localparam int DQW        = 35 - CORDIC_STAGES;   // quotient bits of the residual divide
  localparam int DQIW       = $clog2(DQW);
  localparam int DVW        = XW + 30;              // divide remainder
  localparam int ANW        = 32;                   // half the central angle, Q30

  // Fixed-point constants.
  localparam logic [35:0] DEG5_K  = 36'd25152845341;  // pi/18000000 scaled by 2^57
  localparam logic [17:0] DEG5_KL = DEG5_K[17:0];
  localparam logic [17:0] DEG5_KH = DEG5_K[35:18];
  localparam logic signed [34:0] PI_Q29      = 35'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314857;
  localparam logic signed [34:0] TWO_PI_Q29  = 35'sd3373259426;
  localparam logic signed [XW-1:0] GAIN_INV_Q40 = 44'sd667681663042;
  localparam logic [60:0] ONE_Q60  = 61'd1 << 60;
  localparam logic [23:0] DIST_K   = 24'd12745590;    // twice the sphere radius in metres
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd20100000;

  // CORDIC direction modes.
  localparam logic MODE_ROT = 1'b0;
  localparam logic MODE_VEC = 1'b1;

  localparam logic signed [ZW-1:0] ARC_TAB [0:10] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [RTW-1:0] v;
    logic [RTW-1:0] r;
  } root_t;

  typedef struct packed {
    logic [DVW-1:0]       rem;
    logic [XW-2:0]        dvs;
    logic [DQW-1:0]       quo;
    logic signed [ZW-1:0] z;
    logic                 neg;
    logic                 xpos;
  } div_t;

  // Arctangent of 2^-i in Q30; past the table the angle is taken as 2^-i itself.
  function automatic logic signed [ZW-1:0] arc_step(input logic [SHW-1:0] i);
    logic [32:0] t;
    t = ((33'd1 << 31) >> i) + 33'd1;
    if (i < 5'd11) begin
      arc_step = ARC_TAB[i[3:0]];
    end else begin
      arc_step = $signed(ZW'(t >> 1));
    end
  endfunction

endpackage

FILE: hw/rtl/hpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine proximity check channels
// Valid/ready interfaces for the coordinate pair input and the result output.
// ----------------------------------------------------------------------------
interface hpc_in_if import hpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LAT_W-1:0]  point_lat;
  logic signed [LON_W-1:0]  point_lon;
  logic [KIND_W-1:0]        point_kind;
  logic signed [LAT_W-1:0]  center_lat;
  logic signed [LON_W-1:0]  center_lon;
  logic [KIND_W-1:0]        center_kind;

  modport source (output valid, point_lat, point_lon, point_kind,
                  center_lat, center_lon, center_kind, input ready);
  modport sink   (input valid, point_lat, point_lon, point_kind,
                  center_lat, center_lon, center_kind, output ready);
endinterface

interface hpc_out_if import hpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_m;
  logic              within_res;
  logic              kind_mismatch;

  modport source (output valid, distance_m, within_res, kind_mismatch, input ready);
  modport sink   (input valid, distance_m, within_res, kind_mismatch, output ready);
endinterface

FILE: hw/rtl/hpc_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, in rotation or vectoring mode, with its output register.
// ----------------------------------------------------------------------------
module hpc_cordic_cell import hpc_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SHW-1:0] sh,
  input  logic           vec_mode,
  input  cordic_t        d_i,
  output cordic_t        d_o
);

  cordic_t d_r, d_nxt;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] arc;
  logic dir;

  always_comb begin
    xs  = d_i.x >>> sh;
    ys  = d_i.y >>> sh;
    arc = arc_step(sh);
    // dir high turns the vector counterclockwise.
    if (vec_mode == MODE_VEC) begin
      dir = d_i.y[XW-1] || (d_i.y == '0);
    end else begin
      dir = !d_i.z[ZW-1];
    end
    if (dir) begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - arc;
    end else begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + arc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: hw/rtl/hpc_root_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of a bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
module hpc_root_cell import hpc_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [RKW-1:0] k,
  input  root_t          d_i,
  output root_t          d_o
);

  root_t d_r, d_nxt;
  logic [RTW-1:0] bitv, t;

  always_comb begin
    bitv  = RTW'(1) << {k, 1'b0};
    t     = d_i.r + bitv;
    d_nxt = d_i;
    if (d_i.v >= t) begin
      d_nxt.v = d_i.v - t;
      d_nxt.r = (d_i.r >> 1) + bitv;
    end else begin
      d_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: hw/rtl/hpc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divide cell
// One quotient bit of a restoring divide, registered.
// ----------------------------------------------------------------------------
module hpc_div_cell import hpc_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [DQIW-1:0] k,
  input  div_t            d_i,
  output div_t            d_o
);

  div_t d_r, d_nxt;
  logic [DVW-1:0] trial;

  always_comb begin
    trial = DVW'(d_i.dvs) << k;
    d_nxt = d_i;
    if (d_i.rem >= trial) begin
      d_nxt.rem = d_i.rem - trial;
      d_nxt.quo = d_i.quo | (DQW'(1) << k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: hw/rtl/haversine_proximity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine proximity check
// Great-circle distance between a point and an area center, with a radius
// and point type test.
// ----------------------------------------------------------------------------
// The block takes one coordinate pair per clock and returns one result per
// pair, in order. The pipeline is built from chains of cells: 24 CORDIC
// cells per angle for sine and cosine, 31 square root cells per lane, 24
// vectoring CORDIC cells for the arcsine and 11 divide cells for the residual
// angle. Every stage is one register, so a new transfer can enter on every
// cycle; when a result waits on the output the whole pipeline holds, and
// input transfers are taken again as soon as the output register frees up.
// Coordinates are in units of 1e-5 degree; the distance is truncated to
// whole metres and saturates at 20100000. Accuracy is within one metre
// except for nearly antipodal points.
// Configuration writes must only be issued while no transfer is in flight.
// ----------------------------------------------------------------------------
module haversine_proximity_check import hpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata,
  hpc_in_if.sink            in_if,
  hpc_out_if.source         out_if
);

  localparam int CS    = CORDIC_STAGES;
  localparam int L     = 46 + 2 * CS + DQW;   // register stages, output included
  localparam int H_STG = 4 + CS + 2 + 5;      // stage that holds the clamped h

  // Configuration registers.
  logic [CFG_W-1:0] radius_r;
  logic             type_chk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RADIUS_RST;
      type_chk_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RADIUS:     radius_r   <= cfg_wdata;
        REG_TYPE_CHECK: type_chk_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register can take a
  // new result.
  logic adv;
  logic vld_r [L];
  logic eq_r  [L-1];

  assign adv         = !vld_r[L-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < L; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_if.valid;
      for (int j = 1; j < L; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eq_r[0] <= (in_if.point_kind == in_if.center_kind);
      for (int j = 1; j < L - 1; j++) begin
        eq_r[j] <= eq_r[j-1];
      end
    end
  end

  // Stage 1: the four angles in degrees as sign and magnitude. Lanes 0 and 1
  // are the latitude and longitude differences, lanes 2 and 3 the two
  // latitudes.
  logic signed [26:0] lv [4];
  logic [26:0] mag_nxt [4], mag_r [4];
  logic [3:0]  neg_nxt, neg_r, neg2_r;

  always_comb begin
    lv[0] = {{2{in_if.point_lat[LAT_W-1]}}, in_if.point_lat}
          - {{2{in_if.center_lat[LAT_W-1]}}, in_if.center_lat};
    lv[1] = {in_if.point_lon[LON_W-1], in_if.point_lon}
          - {in_if.center_lon[LON_W-1], in_if.center_lon};
    lv[2] = {{2{in_if.point_lat[LAT_W-1]}}, in_if.point_lat};
    lv[3] = {{2{in_if.center_lat[LAT_W-1]}}, in_if.center_lat};
    for (int l = 0; l < 4; l++) begin
      neg_nxt[l] = lv[l][26];
      mag_nxt[l] = lv[l][26] ? 27'(-lv[l]) : 27'(lv[l]);
    end
  end

  // Stage 2: the degree-to-radian constant is wider than a multiplier, so it
  // is split into two partial products.
  logic [44:0] pl_r [4];
  logic [43:0] ph_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      for (int l = 0; l < 4; l++) begin
        pl_r[l] <= 45'(mag_r[l]) * 45'(DEG5_KL);
        ph_r[l] <= 44'(mag_r[l]) * 44'(DEG5_KH);
      end
      neg2_r <= neg_r;
    end
  end

  // Stage 3: round to radians. Differences are halved by one more shift.
  logic [62:0] psum;
  logic [34:0] pmag;
  logic signed [34:0] ang_nxt [4], ang_r [4];

  always_comb begin
    psum = '0;
    pmag = '0;
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        psum = (63'(ph_r[l]) << 18) + 63'(pl_r[l]) + (63'd1 << 28);
        pmag = 35'(psum >> 29);
      end else begin
        psum = (63'(ph_r[l]) << 18) + 63'(pl_r[l]) + (63'd1 << 27);
        pmag = 35'(psum >> 28);
      end
      ang_nxt[l] = neg2_r[l] ? -$signed(pmag) : $signed(pmag);
    end
  end

  // Stage 4: reduce to [-pi, pi], fold into [-pi/2, pi/2] and note when the
  // cosine changes sign.
  logic signed [34:0] ar;
  logic signed [34:0] a2;
  logic [3:0]  fl_all;
  cordic_t     rot0_nxt [4], rot0_r [4];
  logic [1:0]  flip_r [CS+2];

  always_comb begin
    ar     = '0;
    a2     = '0;
    fl_all = '0;
    for (int l = 0; l < 4; l++) begin
      ar = ang_r[l];
      if (ar > PI_Q29)  ar = ar - TWO_PI_Q29;
      if (ar > PI_Q29)  ar = ar - TWO_PI_Q29;
      if (ar < -PI_Q29) ar = ar + TWO_PI_Q29;
      if (ar < -PI_Q29) ar = ar + TWO_PI_Q29;
      if (ar > HALF_PI_Q29) begin
        ar = PI_Q29 - ar;
        fl_all[l] = 1'b1;
      end else if (ar < -HALF_PI_Q29) begin
        ar = -PI_Q29 - ar;
        fl_all[l] = 1'b1;
      end
      a2 = ar + ar;
      rot0_nxt[l].x = GAIN_INV_Q40;
      rot0_nxt[l].y = '0;
      rot0_nxt[l].z = ZW'(a2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r      <= ang_nxt;
      rot0_r     <= rot0_nxt;
      flip_r[0]  <= fl_all[3:2];
      for (int j = 1; j < CS + 2; j++) begin
        flip_r[j] <= flip_r[j-1];
      end
    end
  end

  // Rotation CORDIC, one chain of cells per angle.
  cordic_t rot_c [4][CS+1];

  for (genvar l = 0; l < 4; l++) begin : g_rot
    assign rot_c[l][0] = rot0_r[l];
    for (genvar k = 0; k < CS; k++) begin : g_cell
      hpc_cordic_cell u_cell (
        .clk      (clk),
        .en       (adv),
        .sh       (SHW'(k)),
        .vec_mode (MODE_ROT),
        .d_i      (rot_c[l][k]),
        .d_o      (rot_c[l][k+1])
      );
    end
  end

  // First-order correction by the residual angle, then rounding to Q30.
  // Lanes 0 and 1 keep the sine, lanes 2 and 3 the cosine.
  logic signed [XW+ZRW-1:0] mp_nxt [4], mp_r [4];
  logic signed [XW-1:0]     base_nxt [4], base_r [4];
  logic signed [ZRW-1:0]    zr;
  logic signed [XW-1:0]     tv;
  logic signed [XW-1:0]     cv;
  logic signed [TW-1:0]     trig_nxt [4], trig_r [4];
  logic [3:0]               fv;

  always_comb begin
    zr = '0;
    for (int l = 0; l < 4; l++) begin
      zr = $signed(rot_c[l][CS].z[ZRW-1:0]);
      if (l < 2) begin
        mp_nxt[l]   = rot_c[l][CS].x * zr;
        base_nxt[l] = rot_c[l][CS].y;
      end else begin
        mp_nxt[l]   = rot_c[l][CS].y * zr;
        base_nxt[l] = rot_c[l][CS].x;
      end
    end
  end

  always_comb begin
    tv = '0;
    cv = '0;
    fv = {flip_r[CS+1], 2'b00};
    for (int l = 0; l < 4; l++) begin
      tv = XW'(mp_r[l] >>> 30);
      if (l < 2) begin
        cv = base_r[l] + tv;
      end else begin
        cv = base_r[l] - tv;
      end
      cv = cv + XW'(512);
      trig_nxt[l] = TW'(cv >>> 10);
      if (fv[l]) begin
        trig_nxt[l] = -trig_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp_r   <= mp_nxt;
      base_r <= base_nxt;
      trig_r <= trig_nxt;
    end
  end

  // h = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2); each multiplier
  // level is registered, and each product rounding has a stage of its own.
  logic signed [63:0] s1sq_m1_r, s1sq_m2_r, s1sq_m3_r, s1sq_m4_r, s1sq_m5_r;
  logic signed [63:0] ccp_m1_r, pp_m3_r, ps_m5_r;
  logic signed [TW-1:0] s2_m1_r, s2_m2_r, s2_m3_r, s2_m4_r;
  logic signed [TW-1:0] cc_nxt, cc_m2_r, p_nxt, p_m4_r;
  logic signed [63:0]   ccr, ppr;
  logic signed [64:0]   hs;
  logic [60:0]          h_nxt, h_r, hq_r;

  always_comb begin
    ccr    = ccp_m1_r + 64'sd536870912;
    cc_nxt = $signed(ccr[61:30]);
    ppr    = pp_m3_r + 64'sd536870912;
    p_nxt  = $signed(ppr[61:30]);
    hs     = {s1sq_m5_r[63], s1sq_m5_r} + {ps_m5_r[63], ps_m5_r};
    if (hs[64]) begin
      h_nxt = '0;
    end else if (hs[63:0] > 64'(ONE_Q60)) begin
      h_nxt = ONE_Q60;
    end else begin
      h_nxt = hs[60:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1sq_m1_r <= trig_r[0] * trig_r[0];
      ccp_m1_r  <= trig_r[2] * trig_r[3];
      s2_m1_r   <= trig_r[1];
      s1sq_m2_r <= s1sq_m1_r;
      cc_m2_r   <= cc_nxt;
      s2_m2_r   <= s2_m1_r;
      s1sq_m3_r <= s1sq_m2_r;
      pp_m3_r   <= cc_m2_r * s2_m2_r;
      s2_m3_r   <= s2_m2_r;
      s1sq_m4_r <= s1sq_m3_r;
      p_m4_r    <= p_nxt;
      s2_m4_r   <= s2_m3_r;
      s1sq_m5_r <= s1sq_m4_r;
      ps_m5_r   <= p_m4_r * s2_m4_r;
      h_r       <= h_nxt;
      hq_r      <= ONE_Q60 - h_nxt;
    end
  end

  // sqrt(h) in lane 0 and sqrt(1 - h) in lane 1.
  root_t rt_c [2][ROOT_STEPS+1];

  assign rt_c[0][0] = '{v: RTW'(h_r),  r: '0};
  assign rt_c[1][0] = '{v: RTW'(hq_r), r: '0};

  for (genvar ln = 0; ln < 2; ln++) begin : g_root
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
      hpc_root_cell u_cell (
        .clk (clk),
        .en  (adv),
        .k   (RKW'(ROOT_STEPS - 1 - k)),
        .d_i (rt_c[ln][k]),
        .d_o (rt_c[ln][k+1])
      );
    end
  end

  // asin(sqrt h) as the angle of (sqrt(1 - h), sqrt h) by vectoring.
  cordic_t vec_c [CS+1];

  assign vec_c[0].x = $signed(XW'({rt_c[1][ROOT_STEPS].r[30:0], 10'b0}));
  assign vec_c[0].y = $signed(XW'({rt_c[0][ROOT_STEPS].r[30:0], 10'b0}));
  assign vec_c[0].z = '0;

  for (genvar k = 0; k < CS; k++) begin : g_vec
    hpc_cordic_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .sh       (SHW'(k)),
      .vec_mode (MODE_VEC),
      .d_i      (vec_c[k]),
      .d_o      (vec_c[k+1])
    );
  end

  // The leftover y/x is added to the angle; it is small, so a short divide
  // with 11 quotient bits covers it.
  div_t div_c [DQW+1];
  logic [XW-1:0] ymag;

  always_comb begin
    ymag            = vec_c[CS].y[XW-1] ? XW'(-vec_c[CS].y) : XW'(vec_c[CS].y);
    div_c[0].rem  = DVW'(ymag) << 30;
    div_c[0].dvs  = vec_c[CS].x[XW-2:0];
    div_c[0].quo  = '0;
    div_c[0].z    = vec_c[CS].z;
    div_c[0].neg  = vec_c[CS].y[XW-1];
    div_c[0].xpos = !vec_c[CS].x[XW-1] && (vec_c[CS].x != '0);
  end

  for (genvar k = 0; k < DQW; k++) begin : g_div
    hpc_div_cell u_cell (
      .clk (clk),
      .en  (adv),
      .k   (DQIW'(DQW - 1 - k)),
      .d_i (div_c[k]),
      .d_o (div_c[k+1])
    );
  end

  // Final angle, distance, the type test and the radius test.
  logic signed [ZW:0] qe, asum;
  logic [ANW-1:0]     ca_nxt, ca_r;
  logic [55:0]        dprod_r;
  logic [25:0]        dq;
  logic [DIST_W-1:0]  dist_nxt, dist_r;
  logic               mis_nxt, mis_r, within_nxt, within_r;

  always_comb begin
    qe = $signed({{(ZW + 1 - DQW){1'b0}}, div_c[DQW].quo});
    if (!div_c[DQW].xpos) begin
      qe = '0;
    end else if (div_c[DQW].neg) begin
      qe = -qe;
    end
    asum   = $signed({div_c[DQW].z[ZW-1], div_c[DQW].z}) + qe;
    ca_nxt = asum[ZW] ? '0 : ANW'(asum);

    dq         = dprod_r[55:30];
    dist_nxt   = (dq > 26'(DIST_MAX)) ? DIST_MAX : dq[DIST_W-1:0];
    mis_nxt    = type_chk_r && !eq_r[L-2];
    within_nxt = !mis_nxt && (dist_nxt <= radius_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_r     <= ca_nxt;
      dprod_r  <= 56'(ca_r) * 56'(DIST_K);
      dist_r   <= dist_nxt;
      mis_r    <= mis_nxt;
      within_r <= within_nxt;
    end
  end

  assign out_if.valid         = vld_r[L-1];
  assign out_if.distance_m    = dist_r;
  assign out_if.within_res    = within_r;
  assign out_if.kind_mismatch = mis_r;

  // A shown distance never passes the saturation limit.
  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.distance_m <= DIST_MAX)
    else $error("distance above saturation limit");

  // A match means the types passed and the distance is inside the radius.
  a_within: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.within_res |->
      !out_if.kind_mismatch && out_if.distance_m <= radius_r)
    else $error("within flag inconsistent with distance or type test");

  // A type mismatch is only reported while type checking is on.
  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind_mismatch |-> type_chk_r)
    else $error("type mismatch with type checking off");

  // The root input h stays inside [0, 1].
  a_h_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[H_STG] |-> h_r <= ONE_Q60)
    else $error("haversine term out of range");

endmodule
